### rtl/core/mxrp_pkg.sv
package mxrp_pkg;

   localparam int CORE_W      = 6;
   localparam int WIDTH_W     = 7;
   localparam int POS_W       = CORE_W + 2;
   localparam int MAX_CORES_DEF = 64;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd4;

   // One quotient bit is produced per divider step.
   localparam int DIV_STEPS = CORE_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_SRC,
      ST_DIV_DST,
      ST_HOP
   } seq_state_type;

endpackage

### rtl/core/mesh_xy_route_path.sv
// XY route generator for a two-dimensional mesh. A request transfer carries a
// source and a destination core number (row-major); the block answers with the
// route one core per response transfer: the source first, then every core along
// X until the column matches, then along Y, with tlast set on the destination.
// Equal source and destination give a single response with tlast set. The row
// width comes from the csr write port (a width of zero acts as one) and may only
// be changed while no route is in flight. Each core number is split into column
// and row by one shared restoring divider that retires one quotient bit per
// cycle, used first for the source and then for the destination; a request
// occupies the block until the last hop of its route is accepted before the next
// one is taken, and each hop holds the response register until it is accepted.
module mesh_xy_route_path
   import mxrp_pkg::*;
#(
   parameter int MAX_CORES = MAX_CORES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // Row width write port.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WIDTH_W-1:0]  csr_wdata,
   // Request: [5:0] source core, [11:6] destination core, [15:12] zero.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,
   // Response: [5:0] hop_core, [7:6] zero.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_CORES + 1);

   seq_state_type st_ff, st_in;

   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CORE_W-1:0]  dvd_ff, dvd_in;
   logic [WIDTH_W-1:0] rem_ff, rem_in;
   logic [CORE_W-1:0]  src_ff, src_in;
   logic [CORE_W-1:0]  dst_ff, dst_in;
   logic [CORE_W-1:0]  x_ff, x_in;
   logic [CORE_W-1:0]  y_ff, y_in;
   logic [CORE_W-1:0]  xd_ff, xd_in;
   logic [CORE_W-1:0]  yd_ff, yd_in;
   logic [POS_W-1:0]   core_ff, core_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [WIDTH_W-1:0] w_eff;
   logic [WIDTH_W:0]   trial;
   logic               fits;
   logic [WIDTH_W:0]   diff;
   logic               div_done;
   logic               at_dst;
   logic               route_end;
   logic               req_xfer;
   logic               rsp_xfer;

   assign w_eff     = (width_ff == '0) ? WIDTH_W'(1) : width_ff;
   assign trial     = {rem_ff, dvd_ff[CORE_W-1]};
   assign fits      = trial >= {1'b0, w_eff};
   assign diff      = trial - {1'b0, w_eff};
   assign div_done  = step_ff == STEP_W'(DIV_STEPS - 1);
   assign at_dst    = (x_ff == xd_ff) && (y_ff == yd_ff);
   assign route_end = at_dst || (cnt_ff == CNT_W'(MAX_CORES));
   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_tvalid && rsp_tready;

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_xfer) st_in = ST_DIV_SRC;
         end
         ST_DIV_SRC: begin
            if (div_done) st_in = ST_DIV_DST;
         end
         ST_DIV_DST: begin
            if (div_done) st_in = ST_HOP;
         end
         ST_HOP: begin
            if (rsp_xfer && route_end) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      csr_ready  = 1'b1;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (st_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_HOP:     rsp_tvalid = 1'b1;
         ST_DIV_SRC,
         ST_DIV_DST: ;
         default:    ;
      endcase
   end

   assign rsp_tdata = {2'b00, core_ff[CORE_W-1:0]};
   assign rsp_tlast = at_dst;

   // Datapath.
   always_comb begin
      width_in = width_ff;
      step_in  = step_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      xd_in    = xd_ff;
      yd_in    = yd_ff;
      core_in  = core_ff;
      cnt_in   = cnt_ff;

      if (csr_valid && csr_ready) width_in = csr_wdata;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               src_in  = req_tdata[CORE_W-1:0];
               dst_in  = req_tdata[2*CORE_W-1:CORE_W];
               dvd_in  = req_tdata[CORE_W-1:0];
               rem_in  = '0;
               step_in = '0;
            end
         end
         ST_DIV_SRC, ST_DIV_DST: begin
            // Restoring division: the dividend register fills with quotient bits.
            dvd_in  = {dvd_ff[CORE_W-2:0], fits};
            rem_in  = fits ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
            step_in = step_ff + STEP_W'(1);
            if (div_done) begin
               step_in = '0;
               if (st_ff == ST_DIV_SRC) begin
                  x_in   = rem_in[CORE_W-1:0];
                  y_in   = dvd_in;
                  dvd_in = dst_ff;
                  rem_in = '0;
               end else begin
                  xd_in   = rem_in[CORE_W-1:0];
                  yd_in   = dvd_in;
                  core_in = {2'b00, src_ff};
                  cnt_in  = CNT_W'(1);
               end
            end
         end
         ST_HOP: begin
            if (rsp_xfer && !route_end) begin
               cnt_in = cnt_ff + CNT_W'(1);
               priority if (x_ff < xd_ff) begin
                  x_in    = x_ff + CORE_W'(1);
                  core_in = core_ff + POS_W'(1);
               end else if (x_ff > xd_ff) begin
                  x_in    = x_ff - CORE_W'(1);
                  core_in = core_ff - POS_W'(1);
               end else if (y_ff < yd_ff) begin
                  y_in    = y_ff + CORE_W'(1);
                  core_in = core_ff + POS_W'(w_eff);
               end else begin
                  y_in    = y_ff - CORE_W'(1);
                  core_in = core_ff - POS_W'(w_eff);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         width_ff <= WIDTH_RESET;
         step_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         st_ff    <= st_in;
         width_ff <= width_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      xd_ff   <= xd_in;
      yd_ff   <= yd_in;
      core_ff <= core_in;
   end

endmodule
